### hw/rtl/tcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_pkg: shared types and constants of the touch calibrate-and-map block
// Field widths, status and register codes, the microcode control word with
// its program table, and the request/response bundles of the serial divider.
// ----------------------------------------------------------------------------
package tcm_pkg;

  // Field widths of the input and result beats.
  localparam int RAW_BITS       = 10;
  localparam int COORD_BITS     = 12;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_BITS      = 32;
  localparam int MARGIN_BITS    = 10;
  localparam int PRESS_BITS     = 10;
  localparam int IDX_BITS       = 3;
  localparam int NUM_POINTS     = 5;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = (COORD_BITS > MARGIN_BITS) ? COORD_BITS : MARGIN_BITS;

  // Reset values of the configuration registers.
  localparam logic [COORD_BITS-1:0]  WIDTH_RESET  = COORD_BITS'(480);
  localparam logic [COORD_BITS-1:0]  HEIGHT_RESET = COORD_BITS'(272);
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(50);

  // Derived datapath widths.
  localparam int DIFF_BITS     = RAW_BITS + 1;
  localparam int DEN_BITS      = RAW_BITS + 2;
  localparam int DEN_MAG_BITS  = RAW_BITS + 1;
  localparam int NUM_BITS      = ((COORD_BITS > MARGIN_BITS + 1) ? COORD_BITS
                                                                 : MARGIN_BITS + 1) + 2;
  localparam int NUM_MAG_BITS  = NUM_BITS - 1;
  localparam int DIVIDEND_BITS = NUM_MAG_BITS + GAIN_FRAC_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);
  localparam int PROD_BITS     = GAIN_BITS + DIFF_BITS;
  localparam int HALF_SH_BITS  = COORD_BITS + GAIN_FRAC_BITS;
  localparam int TOTAL_BITS    = ((PROD_BITS > HALF_SH_BITS) ? PROD_BITS : HALF_SH_BITS) + 1;
  localparam int MAPPED_BITS   = TOTAL_BITS - GAIN_FRAC_BITS;
  localparam int STEP_BITS     = 4;

  // Item kinds and cross codes.
  localparam logic KIND_CAL   = 1'b0;
  localparam logic KIND_TOUCH = 1'b1;

  localparam logic [IDX_BITS-1:0] PT_A = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] PT_B = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] PT_C = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] PT_D = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] PT_E = IDX_BITS'(4);

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OFF  = 2'd1,
    STATUS_DONE = 2'd2,
    STATUS_FAIL = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_CROSS_MARGIN  = 2'd2
  } cfg_reg_e;

  // Datapath operations driven by one control word.
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_MUL_X,
    UOP_MAP_X,
    UOP_MUL_Y,
    UOP_MAP_Y,
    UOP_EMIT_TOUCH,
    UOP_PREP,
    UOP_DIV_X,
    UOP_STORE_GX,
    UOP_DIV_Y,
    UOP_COMMIT,
    UOP_EMIT_FAIL
  } uop_e;

  // Sequencing conditions of a control word.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_DISPATCH,
    COND_ZERO_SPAN,
    COND_DIV_BUSY,
    COND_EMIT
  } cond_e;

  typedef logic [STEP_BITS-1:0] step_t;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    step_t target;
  } ctrl_word_t;

  // Program addresses.
  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_T_MULX  = 4'd1;
  localparam step_t STEP_T_MAPX  = 4'd2;
  localparam step_t STEP_T_MULY  = 4'd3;
  localparam step_t STEP_T_MAPY  = 4'd4;
  localparam step_t STEP_T_EMIT  = 4'd5;
  localparam step_t STEP_C_PREP  = 4'd6;
  localparam step_t STEP_C_CHECK = 4'd7;
  localparam step_t STEP_C_DIVX  = 4'd8;
  localparam step_t STEP_C_WAITX = 4'd9;
  localparam step_t STEP_C_GX    = 4'd10;
  localparam step_t STEP_C_DIVY  = 4'd11;
  localparam step_t STEP_C_WAITY = 4'd12;
  localparam step_t STEP_C_DONE  = 4'd13;
  localparam step_t STEP_C_FAIL  = 4'd14;

  // Divider request and response bundles.
  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [DEN_MAG_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic [DIVIDEND_BITS-1:0] quotient;
  } div_rsp_t;

  // Microcode program: one control word per step.
  function automatic ctrl_word_t ucode_fetch(input step_t step);
    ctrl_word_t cw;
    case (step)
      STEP_IDLE:    cw = '{UOP_NOP,        COND_DISPATCH,  STEP_IDLE};
      STEP_T_MULX:  cw = '{UOP_MUL_X,      COND_NEXT,      STEP_IDLE};
      STEP_T_MAPX:  cw = '{UOP_MAP_X,      COND_NEXT,      STEP_IDLE};
      STEP_T_MULY:  cw = '{UOP_MUL_Y,      COND_NEXT,      STEP_IDLE};
      STEP_T_MAPY:  cw = '{UOP_MAP_Y,      COND_NEXT,      STEP_IDLE};
      STEP_T_EMIT:  cw = '{UOP_EMIT_TOUCH, COND_EMIT,      STEP_IDLE};
      STEP_C_PREP:  cw = '{UOP_PREP,       COND_NEXT,      STEP_IDLE};
      STEP_C_CHECK: cw = '{UOP_NOP,        COND_ZERO_SPAN, STEP_C_FAIL};
      STEP_C_DIVX:  cw = '{UOP_DIV_X,      COND_NEXT,      STEP_IDLE};
      STEP_C_WAITX: cw = '{UOP_NOP,        COND_DIV_BUSY,  STEP_C_WAITX};
      STEP_C_GX:    cw = '{UOP_STORE_GX,   COND_NEXT,      STEP_IDLE};
      STEP_C_DIVY:  cw = '{UOP_DIV_Y,      COND_NEXT,      STEP_IDLE};
      STEP_C_WAITY: cw = '{UOP_NOP,        COND_DIV_BUSY,  STEP_C_WAITY};
      STEP_C_DONE:  cw = '{UOP_COMMIT,     COND_EMIT,      STEP_IDLE};
      STEP_C_FAIL:  cw = '{UOP_EMIT_FAIL,  COND_EMIT,      STEP_IDLE};
      default:      cw = '{UOP_NOP,        COND_JUMP,      STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tcm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_if: valid/ready channels of the touch calibrate-and-map block
// One interface for the input beats and one for the result beats.
// ----------------------------------------------------------------------------
interface tcm_in_if import tcm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [IDX_BITS-1:0]   point_index;
  logic [RAW_BITS-1:0]   raw_x;
  logic [RAW_BITS-1:0]   raw_y;
  logic [PRESS_BITS-1:0] pressure;

  modport source (output valid, kind, point_index, raw_x, raw_y, pressure, input ready);
  modport sink   (input valid, kind, point_index, raw_x, raw_y, pressure, output ready);
endinterface

interface tcm_out_if import tcm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [COORD_BITS-1:0] screen_x;
  logic [COORD_BITS-1:0] screen_y;
  logic [PRESS_BITS-1:0] touch_pressure;
  logic                  axes_swapped;

  modport source (output valid, status, screen_x, screen_y, touch_pressure, axes_swapped,
                  input ready);
  modport sink   (input valid, status, screen_x, screen_y, touch_pressure, axes_swapped,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/touch_calibrate_and_map_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_calibrate_and_map_top: five-point touch calibration and pixel mapping
// Stores raw cross readings, computes signed fixed-point gains on the centre
// cross, and maps raw touch samples to screen coordinates.
// ----------------------------------------------------------------------------
// Usage: corner readings (crosses A to D, and unknown cross codes) are taken
// without leaving the idle step and give no result beat. A touch sample runs
// five microcode steps through a single 32x11 multiplier (two multiply and
// two map steps plus the result step); no new beat is taken until they are
// done. A centre reading (cross E) runs the calibration program, in which
// the serial divider computes both gains in turn, one bit per cycle. The
// input side is ready only while the sequencer sits at its idle step; a
// finished result waits in the output register and does not block the next
// input beat, but a further result waits for that register to empty. The
// user must write configuration through cfg_we_i, cfg_idx_i and cfg_data_i
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module touch_calibrate_and_map_top import tcm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tcm_in_if.sink                   in_if,
  tcm_out_if.source                out_if,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int SAT_BITS = ((DIVIDEND_BITS > GAIN_BITS) ? DIVIDEND_BITS : GAIN_BITS) + 1;

  // Apply sign to a quotient magnitude and saturate to the gain range.
  function automatic logic [GAIN_BITS-1:0] signed_gain(
    input logic [DIVIDEND_BITS-1:0] mag,
    input logic                     neg
  );
    logic [SAT_BITS-1:0] ext;
    logic [SAT_BITS-1:0] lim;
    ext = SAT_BITS'(mag);
    lim = neg ? (SAT_BITS'(1) << (GAIN_BITS - 1))
              : ((SAT_BITS'(1) << (GAIN_BITS - 1)) - SAT_BITS'(1));
    if (ext > lim) begin
      ext = lim;
    end
    if (neg) begin
      ext = ~ext + SAT_BITS'(1);
    end
    return ext[GAIN_BITS-1:0];
  endfunction

  // Magnitude of the difference of two raw readings.
  function automatic logic [RAW_BITS-1:0] abs_diff(
    input logic [RAW_BITS-1:0] a,
    input logic [RAW_BITS-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers.
  logic [COORD_BITS-1:0]  width_q, height_q;
  logic [MARGIN_BITS-1:0] margin_q;

  // Calibration result state.
  logic [GAIN_BITS-1:0] gain_x_q, gain_y_q;
  logic [RAW_BITS-1:0]  centre_x_q, centre_y_q;
  logic                 swap_q;

  // Raw cross store, undefined until written.
  logic [RAW_BITS-1:0] pt_x_q [NUM_POINTS];
  logic [RAW_BITS-1:0] pt_y_q [NUM_POINTS];

  // Sequencer.
  step_t      step_q, step_d;
  ctrl_word_t cw;
  logic       in_fire;
  logic       emit_ok;
  logic       zero_span;
  logic       out_valid_q, out_valid_d;
  logic       out_load;

  // Touch item registers.
  logic [RAW_BITS-1:0]   ux_q, uy_q;
  logic [PRESS_BITS-1:0] pres_q;

  // Calibration working registers.
  logic                       cal_sw_q;
  logic signed [DEN_BITS-1:0] den_x_q, den_y_q;
  logic signed [NUM_BITS-1:0] num_x_q, num_y_q;
  logic [RAW_BITS-1:0]        cen_x_q, cen_y_q;
  logic                       neg_x_q, neg_y_q;

  // Preparation logic.
  logic                       sw_c;
  logic [RAW_BITS-1:0]        px_c [NUM_POINTS];
  logic [RAW_BITS-1:0]        py_c [NUM_POINTS];
  logic signed [DEN_BITS-1:0] den_x_c, den_y_c;
  logic signed [NUM_BITS-1:0] num_x_c, num_y_c;

  // Divider.
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  logic signed [NUM_BITS-1:0] div_num;
  logic signed [DEN_BITS-1:0] div_den;
  logic [NUM_BITS-1:0]        num_abs;
  logic [DEN_BITS-1:0]        den_abs;

  // Multiply and map datapath.
  logic                          axis_y;
  logic [RAW_BITS-1:0]           mul_raw, mul_cen;
  logic [GAIN_BITS-1:0]          mul_gain;
  logic signed [DIFF_BITS-1:0]   diff_c;
  logic signed [PROD_BITS-1:0]   prod_c, prod_q;
  logic [COORD_BITS-1:0]         axis_len;
  logic [COORD_BITS-2:0]         half_c;
  logic signed [TOTAL_BITS-1:0]  total_c, adj_c;
  logic signed [MAPPED_BITS-1:0] mapped_c;
  logic                          off_c;
  logic [COORD_BITS-1:0]         sx_q, sy_q;
  logic                          off_q;

  // Output register.
  logic [1:0]            out_status_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [PRESS_BITS-1:0] out_pres_q;
  logic                  out_swap_q;

  // ------------------------------------------------------------------
  // Handshake and control word
  // ------------------------------------------------------------------
  assign cw          = ucode_fetch(step_q);
  assign in_if.ready = (cw.cond == COND_DISPATCH);
  assign in_fire     = in_if.valid && in_if.ready;
  assign emit_ok     = !out_valid_q || out_if.ready;
  assign zero_span   = (den_x_q == '0) || (den_y_q == '0);
  assign out_load    = emit_ok && ((cw.uop == UOP_EMIT_TOUCH) || (cw.uop == UOP_COMMIT) ||
                                   (cw.uop == UOP_EMIT_FAIL));

  // Next step of the sequencer.
  always_comb begin
    step_d = step_q;
    case (cw.cond)
      COND_NEXT: step_d = step_t'(step_q + 1'b1);
      COND_JUMP: step_d = cw.target;
      COND_DISPATCH: begin
        if (in_fire) begin
          if (in_if.kind == KIND_TOUCH) begin
            step_d = STEP_T_MULX;
          end else if (in_if.point_index == PT_E) begin
            step_d = STEP_C_PREP;
          end
        end
      end
      COND_ZERO_SPAN: step_d = zero_span ? cw.target : step_t'(step_q + 1'b1);
      COND_DIV_BUSY:  step_d = div_rsp.busy ? cw.target : step_t'(step_q + 1'b1);
      COND_EMIT:      step_d = emit_ok ? cw.target : step_q;
      default:        step_d = STEP_IDLE;
    endcase
  end

  // Output valid flag.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      margin_q <= MARGIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SCREEN_WIDTH:  width_q  <= cfg_data_i[COORD_BITS-1:0];
        REG_SCREEN_HEIGHT: height_q <= cfg_data_i[COORD_BITS-1:0];
        REG_CROSS_MARGIN:  margin_q <= cfg_data_i[MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Cross store and touch item capture
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_if.kind == KIND_CAL) && (in_if.point_index <= PT_E)) begin
      pt_x_q[in_if.point_index] <= in_if.raw_x;
      pt_y_q[in_if.point_index] <= in_if.raw_y;
    end
  end

  // Touch readings are exchanged on capture when the axes are swapped.
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_if.kind == KIND_TOUCH)) begin
      ux_q   <= swap_q ? in_if.raw_y : in_if.raw_x;
      uy_q   <= swap_q ? in_if.raw_x : in_if.raw_y;
      pres_q <= in_if.pressure;
    end
  end

  // ------------------------------------------------------------------
  // Calibration preparation: swap decision, spans and numerators
  // ------------------------------------------------------------------
  assign sw_c = abs_diff(pt_x_q[PT_B], pt_x_q[PT_A]) <= abs_diff(pt_y_q[PT_B], pt_y_q[PT_A]);

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      px_c[i] = sw_c ? pt_y_q[i] : pt_x_q[i];
      py_c[i] = sw_c ? pt_x_q[i] : pt_y_q[i];
    end
  end

  assign den_x_c = $signed(DEN_BITS'(px_c[PT_B]) - DEN_BITS'(px_c[PT_A]) +
                           DEN_BITS'(px_c[PT_C]) - DEN_BITS'(px_c[PT_D]));
  assign den_y_c = $signed(DEN_BITS'(py_c[PT_D]) - DEN_BITS'(py_c[PT_A]) +
                           DEN_BITS'(py_c[PT_C]) - DEN_BITS'(py_c[PT_B]));
  assign num_x_c = $signed((NUM_BITS'(width_q) << 1) - (NUM_BITS'(margin_q) << 2));
  assign num_y_c = $signed((NUM_BITS'(height_q) << 1) - (NUM_BITS'(margin_q) << 2));

  always_ff @(posedge clk_i) begin
    if (cw.uop == UOP_PREP) begin
      cal_sw_q <= sw_c;
      den_x_q  <= den_x_c;
      den_y_q  <= den_y_c;
      num_x_q  <= num_x_c;
      num_y_q  <= num_y_c;
      cen_x_q  <= px_c[PT_E];
      cen_y_q  <= py_c[PT_E];
      neg_x_q  <= num_x_c[NUM_BITS-1] ^ den_x_c[DEN_BITS-1];
      neg_y_q  <= num_y_c[NUM_BITS-1] ^ den_y_c[DEN_BITS-1];
    end
  end

  // ------------------------------------------------------------------
  // Gain division on magnitudes; the sign is applied afterwards
  // ------------------------------------------------------------------
  assign div_num = (cw.uop == UOP_DIV_Y) ? num_y_q : num_x_q;
  assign div_den = (cw.uop == UOP_DIV_Y) ? den_y_q : den_x_q;
  assign num_abs = div_num[NUM_BITS-1] ? NUM_BITS'(-div_num) : NUM_BITS'(div_num);
  assign den_abs = div_den[DEN_BITS-1] ? DEN_BITS'(-div_den) : DEN_BITS'(div_den);

  assign div_req.start    = (cw.uop == UOP_DIV_X) || (cw.uop == UOP_DIV_Y);
  assign div_req.dividend = {num_abs[NUM_MAG_BITS-1:0], {GAIN_FRAC_BITS{1'b0}}};
  assign div_req.divisor  = den_abs[DEN_MAG_BITS-1:0];

  tcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Gains, centre and swap decision are committed only on success.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_x_q   <= '0;
      gain_y_q   <= '0;
      centre_x_q <= '0;
      centre_y_q <= '0;
      swap_q     <= 1'b0;
    end else if (cw.uop == UOP_STORE_GX) begin
      gain_x_q <= signed_gain(div_rsp.quotient, neg_x_q);
    end else if (cw.uop == UOP_COMMIT) begin
      gain_y_q   <= signed_gain(div_rsp.quotient, neg_y_q);
      centre_x_q <= cen_x_q;
      centre_y_q <= cen_y_q;
      swap_q     <= cal_sw_q;
    end
  end

  // ------------------------------------------------------------------
  // Mapping: gain * (raw - centre) + half screen, truncated toward zero
  // ------------------------------------------------------------------
  assign axis_y   = (cw.uop == UOP_MUL_Y) || (cw.uop == UOP_MAP_Y);
  assign mul_raw  = axis_y ? uy_q : ux_q;
  assign mul_cen  = axis_y ? centre_y_q : centre_x_q;
  assign mul_gain = axis_y ? gain_y_q : gain_x_q;
  assign diff_c   = $signed({1'b0, mul_raw}) - $signed({1'b0, mul_cen});
  assign prod_c   = $signed(mul_gain) * diff_c;

  assign axis_len = axis_y ? height_q : width_q;
  assign half_c   = axis_len[COORD_BITS-1:1];
  assign total_c  = $signed({{(TOTAL_BITS - PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q}) +
                    $signed(TOTAL_BITS'(half_c) << GAIN_FRAC_BITS);
  assign adj_c    = total_c[TOTAL_BITS-1]
                    ? total_c + $signed(TOTAL_BITS'((1 << GAIN_FRAC_BITS) - 1))
                    : total_c;
  assign mapped_c = adj_c[TOTAL_BITS-1:GAIN_FRAC_BITS];
  assign off_c    = mapped_c[MAPPED_BITS-1] ||
                    (mapped_c[MAPPED_BITS-2:0] >= (MAPPED_BITS - 1)'(axis_len));

  always_ff @(posedge clk_i) begin
    if ((cw.uop == UOP_MUL_X) || (cw.uop == UOP_MUL_Y)) begin
      prod_q <= prod_c;
    end
    if (cw.uop == UOP_MAP_X) begin
      sx_q  <= mapped_c[COORD_BITS-1:0];
      off_q <= off_c;
    end
    if (cw.uop == UOP_MAP_Y) begin
      sy_q  <= mapped_c[COORD_BITS-1:0];
      off_q <= off_q | off_c;
    end
  end

  // ------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_pres_q <= '0;
      out_swap_q <= swap_q;
      if (cw.uop == UOP_EMIT_TOUCH) begin
        if (off_q) begin
          out_status_q <= STATUS_OFF;
        end else begin
          out_status_q <= STATUS_OK;
          out_x_q      <= sx_q;
          out_y_q      <= sy_q;
          out_pres_q   <= pres_q;
        end
      end else if (cw.uop == UOP_COMMIT) begin
        out_status_q <= STATUS_DONE;
        out_swap_q   <= cal_sw_q;
      end else begin
        out_status_q <= STATUS_FAIL;
      end
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.status         = out_status_q;
  assign out_if.screen_x       = out_x_q;
  assign out_if.screen_y       = out_y_q;
  assign out_if.touch_pressure = out_pres_q;
  assign out_if.axes_swapped   = out_swap_q;

endmodule
`default_nettype wire

### hw/rtl/tcm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_div: radix-2 restoring divider for the calibration gains
// Divides an unsigned magnitude by an unsigned nonzero divisor, one quotient
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module tcm_div import tcm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                     busy_q, busy_d;
  logic [DIV_CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [DEN_MAG_BITS-1:0]  rem_q, rem_d;
  logic [DIVIDEND_BITS-1:0] quo_q, quo_d;
  logic [DEN_MAG_BITS-1:0]  den_q, den_d;
  logic [DEN_MAG_BITS:0]    partial;
  logic [DEN_MAG_BITS:0]    trial;
  logic                     fits;

  // One trial subtraction of the shifted remainder.
  assign partial = {rem_q, quo_q[DIVIDEND_BITS-1]};
  assign trial   = partial - {1'b0, den_q};
  assign fits    = partial >= {1'b0, den_q};

  // Next state: load on start, otherwise shift one bit while busy.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? trial[DEN_MAG_BITS-1:0] : partial[DEN_MAG_BITS-1:0];
      quo_d = {quo_q[DIVIDEND_BITS-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_BITS'(1);
      if (cnt_q == DIV_CNT_BITS'(DIVIDEND_BITS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

### hw/rtl/tcm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_checker: port-level assertions for the touch calibrate-and-map block
// Watches the channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module tcm_checker import tcm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_kind_i,
  input logic [IDX_BITS-1:0]   in_point_index_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [1:0]            out_status_i,
  input logic [COORD_BITS-1:0] out_screen_x_i,
  input logic [COORD_BITS-1:0] out_screen_y_i,
  input logic [PRESS_BITS-1:0] out_pressure_i,
  input logic                  out_swapped_i
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_screen_x_i) && $stable(out_screen_y_i) &&
      $stable(out_pressure_i) && $stable(out_swapped_i))
    else $error("result beat changed while stalled");

  // Coordinates and pressure are zero unless the touch mapped on screen.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != STATUS_OK) |->
      (out_screen_x_i == '0) && (out_screen_y_i == '0) && (out_pressure_i == '0))
    else $error("nonzero fields on a result that is not a mapped touch");

  // A touch beat occupies the sequencer for at least the next cycle.
  a_touch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_kind_i == KIND_TOUCH) |=> !in_ready_i)
    else $error("input ready right after a touch beat");

  // A corner reading is stored at once and leaves the input ready.
  a_corner_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_kind_i == KIND_CAL) && (in_point_index_i != PT_E)
      |=> in_ready_i)
    else $error("input stalled after a corner reading");

endmodule

bind touch_calibrate_and_map_top tcm_checker u_tcm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_if.valid),
  .in_ready_i       (in_if.ready),
  .in_kind_i        (in_if.kind),
  .in_point_index_i (in_if.point_index),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_status_i     (out_if.status),
  .out_screen_x_i   (out_if.screen_x),
  .out_screen_y_i   (out_if.screen_y),
  .out_pressure_i   (out_if.touch_pressure),
  .out_swapped_i    (out_if.axes_swapped)
);
`default_nettype wire

### sim/tb_touch_calibrate_and_map_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_calibrate_and_map_top: self-checking bench for touch calibration
// Feeds calibration crosses and touch samples through the input channel. It
// predicts every result beat from its own copy of the stored crosses, gains,
// centre and swap decision, and compares each result beat field by field.
// Both channels idle at random, and the receiver holds off long enough to
// back the block up. Several screen settings are used, the extremes among
// them.
// ----------------------------------------------------------------------------
module tb_touch_calibrate_and_map_top;
  import tcm_pkg::*;

  localparam int          SETTLE_CYCLES  = 100;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int          NUM_PHASES     = 8;
  localparam int          PHASE_ITEMS    = 62;
  localparam longint      GAIN_ONE       = longint'(1) <<< GAIN_FRAC_BITS;
  localparam longint      GAIN_MAX       = 64'sh7FFF_FFFF;
  localparam longint      GAIN_MIN       = -GAIN_MAX - 1;

  typedef struct packed {
    logic                  kind;
    logic [IDX_BITS-1:0]   point_index;
    logic [RAW_BITS-1:0]   raw_x;
    logic [RAW_BITS-1:0]   raw_y;
    logic [PRESS_BITS-1:0] pressure;
  } sample_t;

  typedef struct packed {
    status_e               status;
    logic [COORD_BITS-1:0] scr_x;
    logic [COORD_BITS-1:0] scr_y;
    logic [PRESS_BITS-1:0] press;
    logic                  swapped;
  } report_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  tcm_in_if  sample_ch ();
  tcm_out_if report_ch ();

  touch_calibrate_and_map_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (sample_ch),
    .out_if     (report_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predicted block state and configuration.
  logic [COORD_BITS-1:0]       scr_w;
  logic [COORD_BITS-1:0]       scr_h;
  logic [MARGIN_BITS-1:0]      margin;
  logic [RAW_BITS-1:0]         pt_x [NUM_POINTS];
  logic [RAW_BITS-1:0]         pt_y [NUM_POINTS];
  logic signed [GAIN_BITS-1:0] gain_x;
  logic signed [GAIN_BITS-1:0] gain_y;
  logic [RAW_BITS-1:0]         centre_x;
  logic [RAW_BITS-1:0]         centre_y;
  logic                        swap_q;

  // Stimulus and expectation stores.
  sample_t     sample_q [$];
  report_t     due_reports [$];
  logic [3:0]  written_mask;
  int          counted_items;

  // Channel and bookkeeping state.
  sample_t     next_sample;
  sample_t     taken;
  report_t     want;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  int          next_hold_at;
  int          ready_mode;
  int          mode_left;
  int          reports_seen;
  int          samples_taken;
  int          fail_count;
  int          status_tally [4];
  int unsigned cycle_count;

  // Clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Saturated signed fixed-point gain, truncated toward zero.
  function automatic longint fixed_gain(input longint num, input longint den);
    longint q;
    q = (num * GAIN_ONE) / den;
    if (q > GAIN_MAX) q = GAIN_MAX;
    if (q < GAIN_MIN) q = GAIN_MIN;
    return q;
  endfunction

  // One axis of the raw-to-pixel map, truncated toward zero as a whole.
  function automatic longint map_axis(input logic signed [GAIN_BITS-1:0] g, input longint raw,
                                      input longint centre, input longint half);
    longint total;
    total = longint'(g) * (raw - centre) + half * GAIN_ONE;
    return total / GAIN_ONE;
  endfunction

  // Updates the predicted state for one accepted beat and queues its result, if it gives one.
  task automatic calibrate_or_map(input sample_t s);
    report_t r;
    logic    sw;
    longint  ax, ay, m2, numx, numy, denx, deny, ux, uy, sx, sy;
    longint  cx [NUM_POINTS];
    longint  cy [NUM_POINTS];
    r = '0;
    if (s.kind == KIND_CAL) begin
      if (s.point_index > PT_E) return;
      pt_x[s.point_index] = s.raw_x;
      pt_y[s.point_index] = s.raw_y;
      if (s.point_index != PT_E) return;
      // Axes count as exchanged when A to B moves no more in X than in Y.
      ax = longint'(pt_x[PT_B]) - longint'(pt_x[PT_A]);
      ay = longint'(pt_y[PT_B]) - longint'(pt_y[PT_A]);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      sw = (ax <= ay);
      for (int i = 0; i < NUM_POINTS; i++) begin
        cx[i] = longint'(sw ? pt_y[i] : pt_x[i]);
        cy[i] = longint'(sw ? pt_x[i] : pt_y[i]);
      end
      m2   = 2 * longint'(margin);
      numx = 2 * (longint'(scr_w) - m2);
      numy = 2 * (longint'(scr_h) - m2);
      denx = (cx[PT_B] - cx[PT_A]) + (cx[PT_C] - cx[PT_D]);
      deny = (cy[PT_D] - cy[PT_A]) + (cy[PT_C] - cy[PT_B]);
      // A zero span leaves the previous calibration in place.
      if (denx == 0 || deny == 0) begin
        r.status = STATUS_FAIL;
      end else begin
        gain_x   = GAIN_BITS'(fixed_gain(numx, denx));
        gain_y   = GAIN_BITS'(fixed_gain(numy, deny));
        centre_x = RAW_BITS'(cx[PT_E]);
        centre_y = RAW_BITS'(cy[PT_E]);
        swap_q   = sw;
        r.status = STATUS_DONE;
      end
    end else begin
      ux = longint'(swap_q ? s.raw_y : s.raw_x);
      uy = longint'(swap_q ? s.raw_x : s.raw_y);
      sx = map_axis(gain_x, ux, longint'(centre_x), longint'(scr_w >> 1));
      sy = map_axis(gain_y, uy, longint'(centre_y), longint'(scr_h >> 1));
      if (sx < 0 || sx >= longint'(scr_w) || sy < 0 || sy >= longint'(scr_h)) begin
        r.status = STATUS_OFF;
      end else begin
        r.status = STATUS_OK;
        r.scr_x  = COORD_BITS'(sx);
        r.scr_y  = COORD_BITS'(sy);
        r.press  = s.pressure;
      end
    end
    r.swapped = swap_q;
    due_reports.push_back(r);
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Queues one input beat; unknown crosses do not count as work.
  task automatic push_sample(input logic kind, input logic [IDX_BITS-1:0] idx,
                             input logic [RAW_BITS-1:0] x, input logic [RAW_BITS-1:0] y,
                             input logic [PRESS_BITS-1:0] p);
    sample_t s;
    s.kind        = kind;
    s.point_index = idx;
    s.raw_x       = x;
    s.raw_y       = y;
    s.pressure    = p;
    sample_q.push_back(s);
    if (kind == KIND_CAL && idx < PT_E) written_mask[idx[1:0]] = 1'b1;
    if (kind == KIND_TOUCH || idx <= PT_E) counted_items++;
  endtask

  function automatic logic [RAW_BITS-1:0] jitter(input int v);
    int j;
    j = v + int'($urandom_range(0, 30)) - 15;
    if (j < 0) j = 0;
    if (j > 1023) j = 1023;
    return RAW_BITS'(j);
  endfunction

  // A full set of five crosses with random corners, sometimes mirrored,
  // exchanged or degenerate, corners written in a rotated order.
  task automatic queue_cross_set();
    int                  lo_x, hi_x, lo_y, hi_y, t, start, i;
    logic [RAW_BITS-1:0] px [NUM_POINTS];
    logic [RAW_BITS-1:0] py [NUM_POINTS];
    logic [RAW_BITS-1:0] tmp;
    lo_x = $urandom_range(0, 350);
    hi_x = $urandom_range(650, 1023);
    lo_y = $urandom_range(0, 350);
    hi_y = $urandom_range(650, 1023);
    if ($urandom_range(0, 4) == 0) begin
      t = lo_x; lo_x = hi_x; hi_x = t;
    end
    if ($urandom_range(0, 4) == 0) begin
      t = lo_y; lo_y = hi_y; hi_y = t;
    end
    px[PT_A] = jitter(lo_x); py[PT_A] = jitter(lo_y);
    px[PT_B] = jitter(hi_x); py[PT_B] = jitter(lo_y);
    px[PT_C] = jitter(hi_x); py[PT_C] = jitter(hi_y);
    px[PT_D] = jitter(lo_x); py[PT_D] = jitter(hi_y);
    px[PT_E] = jitter((lo_x + hi_x) / 2);
    py[PT_E] = jitter((lo_y + hi_y) / 2);
    case ($urandom_range(0, 9))
      0: begin
        // Every cross at one spot: both spans vanish.
        for (int k = 1; k < NUM_POINTS; k++) begin
          px[k] = px[PT_A];
          py[k] = py[PT_A];
        end
      end
      1: begin
        // Flat in Y: only the vertical span vanishes.
        for (int k = 1; k < NUM_POINTS; k++) py[k] = py[PT_A];
      end
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        tmp = px[k]; px[k] = py[k]; py[k] = tmp;
      end
    end
    start = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      i = (start + k) % 4;
      push_sample(KIND_CAL, IDX_BITS'(i), px[i], py[i], PRESS_BITS'($urandom));
    end
    push_sample(KIND_CAL, PT_E, px[PT_E], py[PT_E], PRESS_BITS'($urandom));
  endtask

  // Mostly touches and well-formed cross sets, with noise mixed in.
  task automatic fill_random_phase(input int budget);
    int pick, start_count;
    start_count = counted_items;
    queue_cross_set();
    while (counted_items - start_count < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_sample(KIND_TOUCH, IDX_BITS'($urandom), RAW_BITS'($urandom), RAW_BITS'($urandom),
                    PRESS_BITS'($urandom));
      end else if (pick < 80) begin
        queue_cross_set();
      end else if (pick < 88) begin
        push_sample(KIND_CAL, IDX_BITS'($urandom_range(5, 7)), RAW_BITS'($urandom),
                    RAW_BITS'($urandom), PRESS_BITS'($urandom));
      end else if (pick < 95) begin
        push_sample(KIND_CAL, IDX_BITS'($urandom_range(0, 3)), RAW_BITS'($urandom),
                    RAW_BITS'($urandom), PRESS_BITS'($urandom));
      end else if (written_mask == 4'hF) begin
        push_sample(KIND_CAL, PT_E, RAW_BITS'($urandom), RAW_BITS'($urandom),
                    PRESS_BITS'($urandom));
      end
    end
  endtask

  // Writes all three registers; only called while the block is idle.
  task automatic set_screen(input int w, input int h, input int m);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SCREEN_WIDTH;
    cfg_data <= CFG_DATA_BITS'(w);
    @(posedge clk_i);
    cfg_idx  <= REG_SCREEN_HEIGHT;
    cfg_data <= CFG_DATA_BITS'(h);
    @(posedge clk_i);
    cfg_idx  <= REG_CROSS_MARGIN;
    cfg_data <= CFG_DATA_BITS'(m);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    scr_w  = COORD_BITS'(w);
    scr_h  = COORD_BITS'(h);
    margin = MARGIN_BITS'(m);
  endtask

  // Waits until every beat is sent and every result has come, then lets a
  // trailing corner reading finish.
  task automatic drain();
    while (sample_q.size() != 0 || sample_ch.valid || due_reports.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        taken.kind        = sample_ch.kind;
        taken.point_index = sample_ch.point_index;
        taken.raw_x       = sample_ch.raw_x;
        taken.raw_y       = sample_ch.raw_y;
        taken.pressure    = sample_ch.pressure;
        calibrate_or_map(taken);
        samples_taken++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          sample_ch.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          next_sample = sample_q.pop_front();
          sample_ch.valid       <= 1'b1;
          sample_ch.kind        <= next_sample.kind;
          sample_ch.point_index <= next_sample.point_index;
          sample_ch.raw_x       <= next_sample.raw_x;
          sample_ch.raw_y       <= next_sample.raw_y;
          sample_ch.pressure    <= next_sample.pressure;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and stalls on a pattern of its own.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_ch.ready <= 1'b0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        if (due_reports.size() == 0) begin
          $display("%0t: result beat with no sample waiting for it, status %0d", $time,
                   report_ch.status);
          fail_count++;
        end else begin
          want = due_reports.pop_front();
          check_field("status", 32'(want.status), 32'(report_ch.status));
          check_field("screen_x", 32'(want.scr_x), 32'(report_ch.screen_x));
          check_field("screen_y", 32'(want.scr_y), 32'(report_ch.screen_y));
          check_field("touch_pressure", 32'(want.press), 32'(report_ch.touch_pressure));
          check_field("axes_swapped", 32'(want.swapped), 32'(report_ch.axes_swapped));
          status_tally[want.status]++;
        end
        reports_seen++;
      end
      // A long hold-off while the sender still has plenty to offer.
      if (hold_left > 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else if (reports_seen >= next_hold_at && sample_q.size() > 20) begin
        hold_left    = 400;
        next_hold_at = reports_seen + 220;
        report_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (ready_mode)
          0:       report_ch.ready <= 1'b1;
          1:       report_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       report_ch.ready <= ($urandom_range(0, 1) != 0);
          default: report_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("%0t: timed out with %0d samples queued and %0d results due", $time,
             sample_q.size(), due_reports.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni                = 1'b0;
    sample_ch.valid       = 1'b0;
    sample_ch.kind        = KIND_CAL;
    sample_ch.point_index = PT_A;
    sample_ch.raw_x       = '0;
    sample_ch.raw_y       = '0;
    sample_ch.pressure    = '0;
    report_ch.ready       = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = REG_SCREEN_WIDTH;
    cfg_data              = '0;
    cycle_count           = 0;
    scr_w                 = WIDTH_RESET;
    scr_h                 = HEIGHT_RESET;
    margin                = MARGIN_RESET;
    gain_x                = '0;
    gain_y                = '0;
    centre_x              = '0;
    centre_y              = '0;
    swap_q                = 1'b0;
    for (int k = 0; k < NUM_POINTS; k++) begin
      pt_x[k] = '0;
      pt_y[k] = '0;
    end
    for (int k = 0; k < 4; k++) status_tally[k] = 0;
    written_mask  = '0;
    counted_items = 0;
    burst_left    = 0;
    gap_left      = 0;
    hold_left     = 0;
    next_hold_at  = 40;
    ready_mode    = 0;
    mode_left     = 0;
    reports_seen  = 0;
    samples_taken = 0;
    fail_count    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Touches before any calibration land on the screen centre.
    push_sample(KIND_TOUCH, PT_A, '0, '0, '0);
    push_sample(KIND_TOUCH, IDX_BITS'(7), '1, '1, '1);
    // Unknown crosses are dropped.
    push_sample(KIND_CAL, IDX_BITS'(5), '1, '0, '1);
    push_sample(KIND_CAL, IDX_BITS'(7), '0, '1, '0);
    // Upright panel.
    push_sample(KIND_CAL, PT_A, 10'd100, 10'd120, 10'd1);
    push_sample(KIND_CAL, PT_B, 10'd920, 10'd110, 10'd2);
    push_sample(KIND_CAL, PT_C, 10'd910, 10'd900, 10'd3);
    push_sample(KIND_CAL, PT_D, 10'd90, 10'd905, 10'd4);
    push_sample(KIND_CAL, PT_E, 10'd505, 10'd500, 10'd5);
    push_sample(KIND_TOUCH, PT_A, 10'd505, 10'd500, 10'd512);
    push_sample(KIND_TOUCH, PT_B, 10'd0, 10'd1023, 10'd1);
    push_sample(KIND_TOUCH, PT_C, 10'd1023, 10'd0, 10'd1023);
    // Zero span: the upright calibration must survive.
    for (int k = 0; k < NUM_POINTS; k++)
      push_sample(KIND_CAL, IDX_BITS'(k), 10'd512, 10'd512, 10'd0);
    push_sample(KIND_TOUCH, PT_D, 10'd300, 10'd700, 10'd77);
    // Panel with X and Y exchanged.
    push_sample(KIND_CAL, PT_A, 10'd110, 10'd100, 10'd0);
    push_sample(KIND_CAL, PT_B, 10'd100, 10'd920, 10'd0);
    push_sample(KIND_CAL, PT_C, 10'd900, 10'd910, 10'd0);
    push_sample(KIND_CAL, PT_D, 10'd905, 10'd90, 10'd0);
    push_sample(KIND_CAL, PT_E, 10'd500, 10'd505, 10'd0);
    push_sample(KIND_TOUCH, PT_E, 10'd100, 10'd900, 10'd5);
    push_sample(KIND_TOUCH, PT_E, 10'd900, 10'd100, 10'd6);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       set_screen(320, 240, 20);
        1:       set_screen(1, 1, 0);
        2:       set_screen(4095, 4095, 1023);
        3:       set_screen(4095, 1, 1023);
        4:       set_screen(100, 60, 1023);
        5:       set_screen(800, 480, 0);
        6:       set_screen($urandom_range(1, 4095), $urandom_range(1, 4095),
                            $urandom_range(0, 1023));
        default: set_screen(WIDTH_RESET, HEIGHT_RESET, MARGIN_RESET);
      endcase
      fill_random_phase(PHASE_ITEMS);
      drain();
    end

    $display("Covered %0d samples over %0d screen settings: %0d on screen, %0d off screen.",
             samples_taken, NUM_PHASES + 1, status_tally[STATUS_OK], status_tally[STATUS_OFF]);
    $display("Calibrations solved %0d, rejected for zero span %0d; %0d mismatches.",
             status_tally[STATUS_DONE], status_tally[STATUS_FAIL], fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tcm_pkg.sv
hw/rtl/tcm_if.sv
hw/rtl/tcm_div.sv
hw/rtl/touch_calibrate_and_map_top.sv
hw/rtl/tcm_checker.sv
sim/tb_touch_calibrate_and_map_top.sv
